### hw/rtl/culs_pkg.sv
// Shared constants for the unstable log window store: field widths, op and status codes.
package culs_pkg;

	localparam int unsigned LOG_DEPTH_DEF = 64;

	localparam int unsigned IDX_W    = 64;
	localparam int unsigned OP_W     = 3;
	localparam int unsigned STS_W    = 3;
	localparam int unsigned S_DATA_W = 3 * IDX_W;
	localparam int unsigned M_DATA_W = 136;
	localparam int unsigned OUT_PAD_W = M_DATA_W - STS_W - 2 * IDX_W;

	localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
	localparam logic [OP_W-1:0] OP_STABLE     = 3'd1;
	localparam logic [OP_W-1:0] OP_RESTORE    = 3'd2;
	localparam logic [OP_W-1:0] OP_TERM_QUERY = 3'd3;
	localparam logic [OP_W-1:0] OP_LAST_QUERY = 3'd4;
	localparam logic [OP_W-1:0] OP_SLICE      = 3'd5;

	localparam logic [STS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STS_W-1:0] STS_MISS     = 3'd1;
	localparam logic [STS_W-1:0] STS_LO_GT_HI = 3'd2;
	localparam logic [STS_W-1:0] STS_OOB      = 3'd3;
	localparam logic [STS_W-1:0] STS_FULL     = 3'd4;
	localparam logic [STS_W-1:0] STS_GAP      = 3'd5;
	localparam logic [STS_W-1:0] STS_EMPTY    = 3'd6;

endpackage

### hw/rtl/culs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module culs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/consensus_unstable_log_store.sv
// Unstable log window store: a ring of entry terms with append, stable, restore, query, slice.
//
// Usage:
//  - Slave stream (s_*) carries one operation per word; s_tuser holds the op code.
//    Every op gives one result word, except a good slice, which gives one word per
//    entry in [lo,hi), with m_tlast on the final word of the op.
//  - Master stream (m_*) returns results from an output register; m_tlast marks
//    the last word caused by an op.
//  - Timing: append, restore, last-index and rejected ops show their result on
//    m_tvalid the cycle after acceptance. Term query and stable-to read the term
//    RAM, whose read data is registered, and respond from the output register after
//    that read. A slice streams its first entry the same way, then one per cycle while
//    the output register is free. Throughput: one op per cycle for append/restore/
//    last-index while the master takes each word; term query, stable-to and slice take
//    no new op until their last result is loaded, as the term RAM has one read port.
//  - Ops are taken one at a time: s_tready is low while a RAM read is in flight.
//  - A stalled master (m_tready low) holds the output word and stops the slice
//    read-out; s_tready stays low until the output register can take a word.
//  - Reset clears the window (base 0, head 0, count 0) and the output valid.
//    The term RAM is not cleared; only slots written by append are ever read.
module consensus_unstable_log_store #(
	parameter int unsigned LOG_DEPTH = culs_pkg::LOG_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [63:0] entry_index, [127:64] entry_term, [191:128] slice_high
	input  logic [culs_pkg::S_DATA_W-1:0] s_tdata,
	// [2:0] op
	input  logic [culs_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] status, [66:3] result_value, [130:67] result_index, [135:131] zero
	output logic [culs_pkg::M_DATA_W-1:0] m_tdata,
	// last_of_run
	output logic                          m_tlast
);

	import culs_pkg::*;

	localparam int unsigned SLOT_W = $clog2(LOG_DEPTH);
	localparam int unsigned CNT_W  = $clog2(LOG_DEPTH + 1);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	// ring slot arithmetic: a < LOG_DEPTH, b <= LOG_DEPTH, so one subtract wraps it
	function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (sum >= (CNT_W+1)'(LOG_DEPTH)) begin
			sum = sum - (CNT_W+1)'(LOG_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

	// control state
	state_t            state_q;
	logic              out_vld_q;
	logic [IDX_W-1:0]  base_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	// output word
	logic [STS_W-1:0]  out_sts_q;
	logic [IDX_W-1:0]  out_val_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_last_q;

	// op in flight
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  key_idx_q;
	logic [IDX_W-1:0]  key_term_q;
	logic [CNT_W-1:0]  pos_q;
	logic [IDX_W-1:0]  data_idx_s1;   // log index of the word now on the RAM output
	logic [SLOT_W-1:0] nxt_slot_q;    // slot of the next slice entry to read
	logic [CNT_W-1:0]  left_q;        // slice entries still to read after the current one

	// input fields
	logic [OP_W-1:0]   in_op;
	logic [IDX_W-1:0]  in_idx;
	logic [IDX_W-1:0]  in_term;
	logic [IDX_W-1:0]  in_hi;

	assign in_op   = s_tuser;
	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_term = s_tdata[2*IDX_W-1:IDX_W];
	assign in_hi   = s_tdata[3*IDX_W-1:2*IDX_W];

	logic acc, out_free;
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	// window position of the incoming index
	logic [IDX_W-1:0]  diff, hi_span, slice_n, cnt64;
	logic              idx_le_base, idx_ge_base, in_win;
	logic [CNT_W-1:0]  d_c;
	logic [SLOT_W-1:0] first_slot;

	assign cnt64       = IDX_W'(count_q);
	assign diff        = in_idx - base_q;
	assign hi_span     = in_hi - base_q;
	assign slice_n     = in_hi - in_idx;
	assign idx_le_base = in_idx <= base_q;
	assign idx_ge_base = in_idx >= base_q;
	assign in_win      = idx_ge_base && (diff < cnt64);
	assign d_c         = diff[CNT_W-1:0];
	assign first_slot  = ring_add(head_q, d_c);

	// term RAM
	logic              wr_en, rd_en;
	logic [SLOT_W-1:0] wr_addr, rd_addr;
	logic [IDX_W-1:0]  rd_data;

	culs_ram #(
		.WIDTH(IDX_W),
		.DEPTH(LOG_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (wr_en),
		.wr_addr(wr_addr),
		.wr_data(in_term),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// next-step decode
	state_t           nxt_state;
	logic             ld_out, go_read, issue_next;
	logic [STS_W-1:0] ld_sts;
	logic [IDX_W-1:0] ld_val, ld_idx;
	logic             ld_last;
	logic [IDX_W-1:0] base_d;
	logic [SLOT_W-1:0] head_d;
	logic [CNT_W-1:0] count_d, left_d, pos_n;

	assign pos_n = pos_q + CNT_W'(1);

	always_comb begin
		nxt_state  = state_q;
		ld_out     = 1'b0;
		go_read    = 1'b0;
		issue_next = 1'b0;
		ld_sts     = STS_OK;
		ld_val     = '0;
		ld_idx     = '0;
		ld_last    = 1'b1;
		base_d     = base_q;
		head_d     = head_q;
		count_d    = count_q;
		left_d     = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		if (acc) begin
			case (in_op)
				OP_APPEND: begin
					ld_out = 1'b1;
					if (idx_le_base) begin
						// restart the window at this index
						base_d  = in_idx;
						count_d = CNT_W'(1);
						wr_en   = 1'b1;
						wr_addr = head_q;
					end else if (diff > cnt64) begin
						ld_sts = STS_GAP;
					end else if (d_c == CNT_W'(LOG_DEPTH)) begin
						ld_sts = STS_FULL;
					end else begin
						// extend, or truncate at the conflict point
						wr_en   = 1'b1;
						wr_addr = first_slot;
						count_d = d_c + CNT_W'(1);
					end
				end
				OP_STABLE, OP_TERM_QUERY: begin
					if (in_win) begin
						go_read   = 1'b1;
						nxt_state = ST_READ;
						rd_en     = 1'b1;
						rd_addr   = first_slot;
					end else begin
						ld_out = 1'b1;
						ld_sts = STS_MISS;
					end
				end
				OP_RESTORE: begin
					ld_out  = 1'b1;
					count_d = '0;
					base_d  = in_idx + IDX_W'(1);
				end
				OP_LAST_QUERY: begin
					ld_out = 1'b1;
					if (count_q != '0) begin
						ld_val = base_q + cnt64 - IDX_W'(1);
					end else begin
						ld_sts = STS_MISS;
					end
				end
				OP_SLICE: begin
					if (in_idx > in_hi) begin
						ld_out = 1'b1;
						ld_sts = STS_LO_GT_HI;
					end else if (!idx_ge_base || (hi_span > cnt64)) begin
						ld_out = 1'b1;
						ld_sts = STS_OOB;
					end else if (in_idx == in_hi) begin
						ld_out = 1'b1;
						ld_sts = STS_EMPTY;
					end else begin
						go_read   = 1'b1;
						nxt_state = ST_READ;
						rd_en     = 1'b1;
						rd_addr   = first_slot;
						left_d    = slice_n[CNT_W-1:0] - CNT_W'(1);
					end
				end
				default: begin
					ld_out = 1'b1;
					ld_sts = STS_MISS;
				end
			endcase
		end else if ((state_q == ST_READ) && out_free) begin
			ld_out = 1'b1;
			case (op_q)
				OP_SLICE: begin
					ld_val  = rd_data;
					ld_idx  = data_idx_s1;
					ld_last = (left_q == '0);
					if (left_q != '0) begin
						issue_next = 1'b1;
						rd_en      = 1'b1;
						rd_addr    = nxt_slot_q;
					end else begin
						nxt_state = ST_IDLE;
					end
				end
				OP_STABLE: begin
					nxt_state = ST_IDLE;
					if (rd_data == key_term_q) begin
						// drop the prefix through the matched entry
						head_d  = ring_add(head_q, pos_n);
						count_d = count_q - pos_n;
						base_d  = key_idx_q + IDX_W'(1);
					end else begin
						ld_sts = STS_MISS;
					end
				end
				default: begin
					nxt_state = ST_IDLE;
					ld_val    = rd_data;
				end
			endcase
		end
	end

	// state machine, window registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			base_q    <= '0;
			head_q    <= '0;
			count_q   <= '0;
		end else begin
			state_q <= nxt_state;
			base_q  <= base_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (ld_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_sts_q  <= ld_sts;
			out_val_q  <= ld_val;
			out_idx_q  <= ld_idx;
			out_last_q <= ld_last;
		end
		if (go_read) begin
			op_q        <= in_op;
			key_idx_q   <= in_idx;
			key_term_q  <= in_term;
			pos_q       <= d_c;
			data_idx_s1 <= in_idx;
			nxt_slot_q  <= ring_add(first_slot, CNT_W'(1));
			left_q      <= left_d;
		end else if (issue_next) begin
			data_idx_s1 <= data_idx_s1 + IDX_W'(1);
			nxt_slot_q  <= ring_add(nxt_slot_q, CNT_W'(1));
			left_q      <= left_q - CNT_W'(1);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_q, out_val_q, out_sts_q};
	assign m_tlast  = out_last_q;

endmodule
